>>> sv/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; every other file of the block uses this package.
package mcr_pkg;

    // Fixed field widths of the item and result words
    localparam int COORD_W = 16;
    localparam int RAD_W   = 13;
    localparam int COLOR_W = 32;
    localparam int PIX_W   = 17;

    // Decision-variable constants of the midpoint recurrence
    localparam int D_INIT = 3;
    localparam int D_DIAG = 10;
    localparam int D_AXIS = 6;

    // Number of mirrored pixels per point
    localparam int OCTANTS = 8;

    // Input word function codes
    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

    // One queued job for the pixel emitter: a point to mirror, or an empty word
    typedef struct packed {
        logic                      pix;
        logic                      fin;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [PIX_W-1:0]   x;
        logic signed [PIX_W-1:0]   y;
        logic [COLOR_W-1:0]        color;
    } t_job;

endpackage

>>> sv/mcr_if.sv
// Valid/ready stream interfaces for the rasterizer's item and pixel channels.
// Depends on mcr_pkg for field widths.
interface mcr_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic signed [mcr_pkg::COORD_W-1:0] center_x;
    logic signed [mcr_pkg::COORD_W-1:0] center_y;
    logic [mcr_pkg::RAD_W-1:0]          radius;
    logic [mcr_pkg::COLOR_W-1:0]        color;

    modport source (output valid, func, center_x, center_y, radius, color, input ready);
    modport sink   (input valid, func, center_x, center_y, radius, color, output ready);
endinterface

interface mcr_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mcr_pkg::PIX_W-1:0]   pixel_x;
    logic signed [mcr_pkg::PIX_W-1:0]   pixel_y;
    logic [mcr_pkg::COLOR_W-1:0]        pixel_color;
    logic                              pixel_valid;
    logic                              last;
    logic                              finished;

    modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_valid, last, finished,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, pixel_valid, last, finished,
                    output ready);
endinterface

>>> sv/mcr_front.sv
// Front end: accepts start/step words, runs the midpoint recurrence, builds jobs.
// Depends on mcr_pkg and mcr_in_if.
module mcr_front #(
    parameter int RADIUS_BITS = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcr_in_if.sink        i_in,
    output mcr_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_ready
);
    import mcr_pkg::*;

    localparam int XW = RADIUS_BITS + 1;
    localparam int YW = RADIUS_BITS + 2;
    localparam int DW = RADIUS_BITS + 5;

    logic                     r_active, n_active;
    logic [XW-1:0]            r_x, n_x;
    logic signed [YW-1:0]     r_y, n_y;
    logic signed [DW-1:0]     r_d, n_d;
    logic signed [COORD_W-1:0] r_cx, n_cx;
    logic signed [COORD_W-1:0] r_cy, n_cy;
    logic [COLOR_W-1:0]       r_color, n_color;

    logic                     accept;
    logic                     is_step;
    logic [15:0]              rad_ext;
    logic [RADIUS_BITS-1:0]   rad;
    logic [XW-1:0]            x_inc;
    logic signed [YW-1:0]     y_dec;
    logic signed [DW-1:0]     x_inc_d;
    logic signed [DW-1:0]     y_dec_d;
    logic signed [DW-1:0]     diff_d;
    logic                     fin_cur;
    logic                     fin_new;

    assign accept  = i_in.valid && i_in.ready;
    assign is_step = (i_in.func == FUNC_STEP);
    assign i_in.ready = i_job_ready;

    // Keep only the low radius bits
    assign rad_ext = 16'(i_in.radius);
    assign rad     = rad_ext[RADIUS_BITS-1:0];

    // Candidate next point
    assign x_inc   = r_x + 1'b1;
    assign y_dec   = r_y - $signed(YW'(1));
    assign x_inc_d = $signed(DW'(x_inc));
    assign y_dec_d = DW'(y_dec);
    assign diff_d  = x_inc_d - y_dec_d;

    // Circle completes once y drops below x
    assign fin_cur = r_y < $signed({1'b0, r_x});
    assign fin_new = n_y < $signed({1'b0, n_x});

    // Next state of the recurrence
    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_d      = r_d;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_color  = r_color;
        if (!is_step) begin
            n_cx     = i_in.center_x;
            n_cy     = i_in.center_y;
            n_color  = i_in.color;
            n_x      = '0;
            n_y      = $signed(YW'(rad));
            n_d      = $signed(DW'(D_INIT)) - $signed(DW'({rad, 1'b0}));
            n_active = 1'b1;
        end else if (r_active) begin
            n_x = x_inc;
            if (r_d > 0) begin
                n_y = y_dec;
                n_d = r_d + (diff_d <<< 2) + $signed(DW'(D_DIAG));
            end else begin
                n_d = r_d + (x_inc_d <<< 2) + $signed(DW'(D_AXIS));
            end
            if (n_y < $signed({1'b0, n_x})) begin
                n_active = 1'b0;
            end
        end
    end

    // Build the job word from the updated point
    always_comb begin
        o_job_valid = accept;
        o_job.pix   = !is_step || r_active;
        o_job.fin   = is_step && (r_active ? fin_new : fin_cur);
        o_job.cx    = n_cx;
        o_job.cy    = n_cy;
        o_job.x     = PIX_W'($signed({1'b0, n_x}));
        o_job.y     = PIX_W'(n_y);
        o_job.color = n_color;
    end

    // Hold recurrence state between words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_color  <= '0;
        end else if (accept) begin
            r_active <= n_active;
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_color  <= n_color;
        end
    end

endmodule

>>> sv/mcr_queue.sv
// Two-entry job queue between the front end and the pixel emitter.
// Depends on mcr_pkg for the job type.
module mcr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mcr_pkg::t_job i_data,
    input  logic          i_push,
    output logic          o_ready,
    output mcr_pkg::t_job o_data,
    output logic          o_valid,
    input  logic          i_pop
);
    import mcr_pkg::*;

    t_job       r_mem [2];
    logic       r_head;
    logic       r_tail;
    logic [1:0] r_count;
    logic       push_ok;
    logic       pop_ok;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_head];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_tail] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push_ok) begin
                r_tail <= !r_tail;
            end
            if (pop_ok) begin
                r_head <= !r_head;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> sv/mcr_back.sv
// Pixel emitter: expands each job into eight mirrored pixels or one empty word.
// Depends on mcr_pkg and mcr_out_if.
module mcr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mcr_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    mcr_out_if.source     o_out
);
    import mcr_pkg::*;

    localparam int IDX_W = $clog2(OCTANTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(OCTANTS - 1);

    logic [IDX_W-1:0]         r_idx;
    logic                     r_valid;
    logic signed [PIX_W-1:0]  r_px;
    logic signed [PIX_W-1:0]  r_py;
    logic [COLOR_W-1:0]       r_color;
    logic                     r_pix;
    logic                     r_last;
    logic                     r_fin;

    logic                     load;
    logic signed [PIX_W-1:0]  cx_ext;
    logic signed [PIX_W-1:0]  cy_ext;
    logic signed [PIX_W-1:0]  sel_a;
    logic signed [PIX_W-1:0]  sel_b;
    logic signed [PIX_W-1:0]  n_px;
    logic signed [PIX_W-1:0]  n_py;

    assign load      = i_job_valid && (!r_valid || o_out.ready);
    assign o_job_pop = load && (!i_job.pix || r_idx == IDX_LAST);

    // Mirror the point: bit 2 swaps x and y, bit 0 negates column, bit 1 negates row
    always_comb begin
        cx_ext = PIX_W'(i_job.cx);
        cy_ext = PIX_W'(i_job.cy);
        sel_a  = r_idx[2] ? i_job.y : i_job.x;
        sel_b  = r_idx[2] ? i_job.x : i_job.y;
        n_px   = r_idx[0] ? cx_ext - sel_a : cx_ext + sel_a;
        n_py   = r_idx[1] ? cy_ext - sel_b : cy_ext + sel_b;
    end

    // Advance pixel index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= (i_job.pix && r_idx != IDX_LAST) ? r_idx + 1'b1 : '0;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_fin <= i_job.fin;
            if (i_job.pix) begin
                r_px    <= n_px;
                r_py    <= n_py;
                r_color <= i_job.color;
                r_pix   <= 1'b1;
                r_last  <= (r_idx == IDX_LAST);
            end else begin
                r_px    <= '0;
                r_py    <= '0;
                r_color <= '0;
                r_pix   <= 1'b0;
                r_last  <= 1'b1;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.pixel_x     = r_px;
    assign o_out.pixel_y     = r_py;
    assign o_out.pixel_color = r_color;
    assign o_out.pixel_valid = r_pix;
    assign o_out.last        = r_last;
    assign o_out.finished    = r_fin;

endmodule

>>> sv/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer: a start word loads center, radius and color and yields the
// eight mirrored pixels of (0, r); each step word advances the midpoint recurrence one
// point and yields its eight mirrored pixels, flagged finished on the step where y falls
// below x; a step with no circle in progress yields one word with no pixel. The pixel
// channel carries one word per cycle while the receiver is ready, so a start or step
// occupies the output for eight words and an empty step for one; the eight-pixel
// expansion in the emitter bounds the sustained item rate. The front end updates the
// recurrence in the cycle it accepts a word and can run up to two words ahead through a
// two-entry job queue; on an empty path a job crosses the queue and the output register.
// Depends on mcr_pkg, mcr_if, mcr_front, mcr_queue and mcr_back.
module midpoint_circle_rasterizer #(
    parameter int RADIUS_BITS = 13
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcr_in_if.sink    i_in,
    mcr_out_if.source o_out
);
    import mcr_pkg::*;

    t_job front_job;
    logic front_valid;
    logic queue_ready;
    t_job head_job;
    logic head_valid;
    logic head_pop;

    mcr_front #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (queue_ready)
    );

    mcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (front_job),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .o_data  (head_job),
        .o_valid (head_valid),
        .i_pop   (head_pop)
    );

    mcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (head_valid),
        .o_job_pop   (head_pop),
        .o_out       (o_out)
    );

endmodule

>>> sv/mcr_checker.sv
// Port-level checks on the rasterizer's pixel channel, bound to the top level.
// Depends on mcr_pkg for field widths.
module mcr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic signed [mcr_pkg::PIX_W-1:0] i_pixel_x,
    input logic signed [mcr_pkg::PIX_W-1:0] i_pixel_y,
    input logic [mcr_pkg::COLOR_W-1:0]   i_pixel_color,
    input logic                          i_pixel_valid,
    input logic                          i_last,
    input logic                          i_finished
);
    import mcr_pkg::*;

    // Drop any word in flight on reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("pixel word valid right after reset");

    // Hold a stalled word
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("pixel word withdrawn while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_pixel_x) && $stable(i_pixel_y)
            && $stable(i_pixel_color) && $stable(i_pixel_valid)
            && $stable(i_last) && $stable(i_finished))
        else $error("pixel word changed while stalled");

    // An empty word closes its item and carries no coordinates
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_pixel_valid |-> i_last && i_pixel_x == '0 && i_pixel_y == '0
            && i_pixel_color == '0)
        else $error("empty word with pixel data or without last");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_pixel_x     (o_out.pixel_x),
    .i_pixel_y     (o_out.pixel_y),
    .i_pixel_color (o_out.pixel_color),
    .i_pixel_valid (o_out.pixel_valid),
    .i_last        (o_out.last),
    .i_finished    (o_out.finished)
);

>>> tb/tb_top.sv
// Self-checking testbench for midpoint_circle_rasterizer: drives start and step words,
// predicts every pixel word, and compares the pixel stream field by field.
// Depends on mcr_pkg, mcr_if and the rasterizer RTL.
`timescale 1ns / 100ps

module tb_top;
    import mcr_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 12;
    localparam int RADIUS_BITS    = 13;
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLD_AT        = 60;
    localparam int HOLD_CYCLES    = 500;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int REPORT_LIMIT   = 10;

    // One input word as the driver offers it
    typedef struct {
        t_func                     func;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RAD_W-1:0]          radius;
        logic [COLOR_W-1:0]        color;
    } circle_cmd_t;

    // One pixel word as the block should emit it
    typedef struct packed {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic [COLOR_W-1:0]      color;
        logic                    pv;
        logic                    last;
        logic                    fin;
    } pixel_word_t;

    logic i_clk;
    logic i_rst_n;

    mcr_in_if  in_bus ();
    mcr_out_if out_bus ();

    midpoint_circle_rasterizer #(
        .RADIUS_BITS(RADIUS_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    // Stimulus and expectation stores
    circle_cmd_t circle_cmds [$];
    pixel_word_t expected_pixels [$];
    circle_cmd_t offered;

    // Predictor state at the block's widths
    logic                      drawing;
    logic [13:0]               pos_x;
    logic signed [14:0]        pos_y;
    logic signed [17:0]        dv;
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    logic [COLOR_W-1:0]        ink;

    // Idling controls and bookkeeping
    int send_idle_pct;
    int recv_idle_pct;
    int items_taken;
    int hold_cnt;
    logic hold_armed;
    int errors;
    int reported;
    int words_checked;
    int pixels_checked;
    int starts_seen;
    int circles_done;
    pixel_word_t got;
    pixel_word_t want;

    // Clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Queue the eight mirrored pixels of the current point
    task automatic push_octants(input logic fin);
        int cx, cy, x, y;
        int px [OCTANTS];
        int py [OCTANTS];
        pixel_word_t w;
        cx = org_x;
        cy = org_y;
        x  = int'(pos_x);
        y  = int'(pos_y);
        px = '{cx + x, cx - x, cx + x, cx - x, cx + y, cx - y, cx + y, cx - y};
        py = '{cy + y, cy + y, cy - y, cy - y, cy + x, cy + x, cy - x, cy - x};
        for (int k = 0; k < OCTANTS; k++) begin
            w.px    = PIX_W'(px[k]);
            w.py    = PIX_W'(py[k]);
            w.color = ink;
            w.pv    = 1'b1;
            w.last  = (k == OCTANTS - 1);
            w.fin   = fin;
            expected_pixels.push_back(w);
        end
    endtask

    // Advance the predicted circle by one accepted word
    task automatic rasterize_word(input circle_cmd_t cmd);
        int x, y, d, rad;
        logic fin;
        pixel_word_t w;
        if (cmd.func == FUNC_START) begin
            rad     = int'(cmd.radius) & ((1 << RADIUS_BITS) - 1);
            org_x   = cmd.cx;
            org_y   = cmd.cy;
            ink     = cmd.color;
            pos_x   = '0;
            pos_y   = 15'(rad);
            dv      = 18'(D_INIT - 2 * rad);
            drawing = 1'b1;
            starts_seen++;
            push_octants(1'b0);
        end else if (!drawing) begin
            w      = '0;
            w.last = 1'b1;
            w.fin  = (int'(pos_y) < int'(pos_x));
            expected_pixels.push_back(w);
        end else begin
            x = int'(pos_x) + 1;
            y = int'(pos_y);
            d = int'(dv);
            if (d > 0) begin
                y = y - 1;
                d = d + 4 * (x - y) + D_DIAG;
            end else begin
                d = d + 4 * x + D_AXIS;
            end
            pos_x = 14'(x);
            pos_y = 15'(y);
            dv    = 18'(d);
            fin   = (y < x);
            if (fin) begin
                drawing = 1'b0;
                circles_done++;
            end
            push_octants(fin);
        end
    endtask

    // Build a word with random content for every field but the function code
    function automatic circle_cmd_t random_cmd(input t_func f);
        circle_cmd_t c;
        c.func   = f;
        c.cx     = COORD_W'($urandom_range(0, 65535));
        c.cy     = COORD_W'($urandom_range(0, 65535));
        c.radius = RAD_W'($urandom_range(0, 8191));
        c.color  = $urandom();
        return c;
    endfunction

    function automatic circle_cmd_t start_cmd(input int cx, input int cy, input int r,
                                              input logic [COLOR_W-1:0] color);
        circle_cmd_t c;
        c.func   = FUNC_START;
        c.cx     = COORD_W'(cx);
        c.cy     = COORD_W'(cy);
        c.radius = RAD_W'(r);
        c.color  = color;
        return c;
    endfunction

    task automatic queue_steps(input int n);
        for (int k = 0; k < n; k++) circle_cmds.push_back(random_cmd(FUNC_STEP));
    endtask

    // Queue mostly complete small circles, plus stray steps and abandoned circles
    task automatic queue_random_circles(input int n_items);
        int pushed, roll, r, n;
        circle_cmd_t c;
        pushed = 0;
        while (pushed < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                n = 1;
            end else if (roll < 18) begin
                // random radius over the full range, at most six steps, then mostly left behind
                n = $urandom_range(0, 6);
                circle_cmds.push_back(random_cmd(FUNC_START));
                pushed++;
            end else begin
                r = (roll < 28) ? $urandom_range(21, 120) : $urandom_range(0, 20);
                n = (r * 707) / 1000 + 1;
                n = (roll < 28) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
                c = random_cmd(FUNC_START);
                c.radius = RAD_W'(r);
                circle_cmds.push_back(c);
                pushed++;
            end
            queue_steps(n);
            pushed += n;
        end
    endtask

    // Hold off until every queued word is sent and every pixel word has come back
    task automatic wait_drained();
        while (circle_cmds.size() != 0 || in_bus.valid || expected_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // Driver: offer queued words, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            items_taken  <= 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                rasterize_word(offered);
                items_taken <= items_taken + 1;
            end
            if (!(in_bus.valid && !in_bus.ready)) begin
                if (circle_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered = circle_cmds.pop_front();
                    in_bus.valid    <= 1'b1;
                    in_bus.func     <= offered.func;
                    in_bus.center_x <= offered.cx;
                    in_bus.center_y <= offered.cy;
                    in_bus.radius   <= offered.radius;
                    in_bus.color    <= offered.color;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once enough words have gone in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt   <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && items_taken >= HOLD_AT) begin
            hold_cnt   <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Monitor: compare each accepted pixel word with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got.px    = out_bus.pixel_x;
                got.py    = out_bus.pixel_y;
                got.color = out_bus.pixel_color;
                got.pv    = out_bus.pixel_valid;
                got.last  = out_bus.last;
                got.fin   = out_bus.finished;
                if (expected_pixels.size() == 0) begin
                    errors++;
                    if (reported < REPORT_LIMIT) begin
                        reported++;
                        $display("ERROR: unexpected pixel word x=%0d y=%0d color=%h pv=%b",
                                 got.px, got.py, got.color, got.pv);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    words_checked++;
                    if (want.pv) pixels_checked++;
                    if (got.px !== want.px || got.py !== want.py || got.color !== want.color ||
                        got.pv !== want.pv || got.last !== want.last || got.fin !== want.fin) begin
                        errors++;
                        if (reported < REPORT_LIMIT) begin
                            reported++;
                            $display("ERROR: word %0d expected x=%0d y=%0d c=%h v%b l%b f%b",
                                     words_checked, want.px, want.py, want.color, want.pv,
                                     want.last, want.fin);
                            $display("       got            x=%0d y=%0d c=%h v%b l%b f%b",
                                     got.px, got.py, got.color, got.pv, got.last, got.fin);
                        end
                    end
                end
            end
            out_bus.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Reset, stimulus phases and verdict
    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.func        = FUNC_START;
        in_bus.center_x    = '0;
        in_bus.center_y    = '0;
        in_bus.radius      = '0;
        in_bus.color       = '0;
        out_bus.ready      = 1'b0;
        drawing            = 1'b0;
        pos_x              = '0;
        pos_y              = '0;
        dv                 = '0;
        org_x              = '0;
        org_y              = '0;
        ink                = '0;
        errors             = 0;
        reported           = 0;
        words_checked      = 0;
        pixels_checked     = 0;
        starts_seen        = 0;
        circles_done       = 0;
        send_idle_pct      = 8;
        recv_idle_pct      = 63;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: step from reset, extreme centers and radii, abandon, full small circle
        queue_steps(1);
        circle_cmds.push_back(start_cmd(32767, -32768, 0, 32'hFFFF_FFFF));
        queue_steps(2);
        circle_cmds.push_back(start_cmd(-32768, 32767, 8191, 32'h0000_0000));
        queue_steps(2);
        circle_cmds.push_back(start_cmd(0, 0, 1, 32'hA5A5_5A5A));
        queue_steps(3);
        circle_cmds.push_back(start_cmd(-1, 1, 5, 32'h5A5A_A5A5));
        queue_steps(6);
        circle_cmds.push_back(start_cmd(32767, 32767, 8191, 32'h0123_4567));
        queue_steps(1);
        circle_cmds.push_back(start_cmd(-32768, -32768, 8191, 32'hFEDC_BA98));
        queue_steps(1);
        wait_drained();

        // Random phases with shifting idle patterns
        queue_random_circles(RANDOM_ITEMS / 3);
        wait_drained();
        send_idle_pct = 63;
        recv_idle_pct = 8;
        queue_random_circles(RANDOM_ITEMS / 3);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_circles(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            errors += expected_pixels.size();
            $display("ERROR: %0d pixel words never arrived", expected_pixels.size());
        end

        $display("Ran %0d input words (%0d starts, %0d circles completed).",
                 items_taken, starts_seen, circles_done);
        $display("Checked %0d output words, %0d of them pixels; %0d mismatches.",
                 words_checked, pixels_checked, errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("ERROR: timeout waiting for pixel words");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
